FILE: hw/rtl/pews_pkg.sv
// Package for the PPS edge-window scheduler: field widths, register map codes,
// the result beat struct and the microsecond to nanosecond scaling helper.
// No dependencies.
package pews_pkg;

    localparam int unsigned TIME_W  = 63;
    localparam int unsigned US_W    = 20;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned NS_W    = 31;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    localparam logic [NS_W-1:0] NS_PER_US = NS_W'(1000);

    // Register indexes (word address paddr[4:2])
    typedef enum logic [2:0] {
        REG_CAPTURE_LEVEL = 3'd0,
        REG_POLL_PERIOD   = 3'd1,
        REG_GUARD_TIME    = 3'd2,
        REG_READ_LIMIT    = 3'd3,
        REG_PULSE_INTERVL = 3'd4
    } reg_index_t;

    localparam logic              RST_CAPTURE_LEVEL = 1'b1;
    localparam logic [US_W-1:0]    RST_POLL_PERIOD   = US_W'(100);
    localparam logic [US_W-1:0]    RST_GUARD_TIME    = US_W'(15);
    localparam logic [COUNT_W-1:0] RST_READ_LIMIT    = COUNT_W'(2000);
    localparam logic [US_W-1:0]    RST_PULSE_INTERVL = US_W'(1000000);

    typedef struct packed {
        logic [TIME_W-1:0] next_delay_ns;
        logic              wait_mode;
        logic              pulse_valid;
        logic [TIME_W-1:0] pulse_stamp_ns;
        logic              pulse_kind;
        logic              pulse_missed;
    } result_t;

    // (a - b) * 1000, zero when a <= b; a and b stay below 2^21
    function automatic logic [NS_W-1:0] us_diff_to_ns(input logic [US_W:0] a,
                                                      input logic [US_W:0] b);
        logic [NS_W-1:0] diff;
        begin
            diff = NS_W'(a - b);
            if (a <= b)
            begin
                us_diff_to_ns = '0;
            end
            else
            begin
                us_diff_to_ns = NS_W'(diff * NS_PER_US);
            end
        end
    endfunction

endpackage

FILE: hw/rtl/pps_edge_window_scheduler.sv
// Top level of the PPS edge-window scheduler: APB register bank, input
// register, single-pass scheduling logic and result register.
// Depends on pews_pkg.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  item      | item_valid / item_stall | pin_level, reads_done, now_ns, stamp_ns
//  result    | result_valid/result_stall| next_delay_ns, wait_mode, pulse_valid,
//            |                         | pulse_stamp_ns, pulse_kind, pulse_missed
//  config    | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied high)
//
// One beat per cycle while result_stall does not hold the result register; a result
// leaves through the input register, then the result register holding the one-pass decision.
// Reset returns to polling with no previous pulse and restores register defaults.
// item_stall rises only while the input register is full and the result register
// is held by result_stall.
module pps_edge_window_scheduler
    import pews_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                pin_level,
    input  logic [COUNT_W-1:0]  reads_done,
    input  logic [TIME_W-1:0]   now_ns,
    input  logic [TIME_W-1:0]   stamp_ns,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [TIME_W-1:0]   next_delay_ns,
    output logic                wait_mode,
    output logic                pulse_valid,
    output logic [TIME_W-1:0]   pulse_stamp_ns,
    output logic                pulse_kind,
    output logic                pulse_missed
);

    // Configuration registers
    logic               capture_level_reg;
    logic [US_W-1:0]    poll_period_reg;
    logic [US_W-1:0]    guard_time_reg;
    logic [COUNT_W-1:0] read_limit_reg;
    logic [US_W-1:0]    pulse_interval_reg;

    // Scheduler state
    logic               mode_wait_reg,   mode_wait_next;
    logic               last_pin_reg,    last_pin_next;
    logic [TIME_W-1:0]  last_time_reg,   last_time_next;
    logic               last_ok_reg,     last_ok_next;

    // Input register
    logic               s1_valid_reg;
    logic               pin_reg;
    logic [COUNT_W-1:0] reads_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  stamp_reg;

    // Result register
    logic               out_valid_reg;
    result_t            out_reg, out_next;

    logic               cfg_write;
    reg_index_t         cfg_index;
    logic               advance;
    logic               load;
    logic               fire;

    logic [US_W:0]      poll_ext;
    logic [US_W:0]      half_poll;
    logic [US_W:0]      interval_ext;
    logic [NS_W-1:0]    poll_ns;
    logic [NS_W-1:0]    arm_ns;
    logic [NS_W-1:0]    first_ns;
    logic [NS_W-1:0]    guard_ns;
    logic [TIME_W:0]    elapsed;
    logic [TIME_W-1:0]  period;
    logic [TIME_W-1:0]  measured_ns;
    logic               caught;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_level_reg  <= RST_CAPTURE_LEVEL;
            poll_period_reg    <= RST_POLL_PERIOD;
            guard_time_reg     <= RST_GUARD_TIME;
            read_limit_reg     <= RST_READ_LIMIT;
            pulse_interval_reg <= RST_PULSE_INTERVL;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CAPTURE_LEVEL: capture_level_reg  <= pwdata[0];
                REG_POLL_PERIOD:   poll_period_reg    <= pwdata[US_W-1:0];
                REG_GUARD_TIME:    guard_time_reg     <= pwdata[US_W-1:0];
                REG_READ_LIMIT:    read_limit_reg     <= pwdata[COUNT_W-1:0];
                REG_PULSE_INTERVL: pulse_interval_reg <= pwdata[US_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_CAPTURE_LEVEL: prdata = DATA_W'(capture_level_reg);
            REG_POLL_PERIOD:   prdata = DATA_W'(poll_period_reg);
            REG_GUARD_TIME:    prdata = DATA_W'(guard_time_reg);
            REG_READ_LIMIT:    prdata = DATA_W'(read_limit_reg);
            REG_PULSE_INTERVL: prdata = DATA_W'(pulse_interval_reg);
            default:           prdata = '0;
        endcase
    end

    // Pipeline handshake: the result register moves when empty or taken
    assign advance    = !out_valid_reg || !result_stall;
    assign item_stall = s1_valid_reg && !advance;
    assign load       = item_valid && !item_stall;
    assign fire       = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pin_reg   <= pin_level;
            reads_reg <= reads_done;
            now_reg   <= now_ns;
            stamp_reg <= stamp_ns;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    // Delays derived from the registers
    assign poll_ext     = (US_W+1)'(poll_period_reg);
    assign half_poll    = (US_W+1)'(poll_period_reg >> 1);
    assign interval_ext = (US_W+1)'(pulse_interval_reg);
    assign poll_ns      = us_diff_to_ns(poll_ext, '0);
    assign arm_ns       = us_diff_to_ns(interval_ext, poll_ext + half_poll);
    assign first_ns     = us_diff_to_ns(interval_ext, half_poll);
    assign guard_ns     = us_diff_to_ns((US_W+1)'(guard_time_reg), '0);

    // Measured period; a clock going backwards counts as zero
    assign elapsed = {1'b0, now_reg} - {1'b0, last_time_reg};
    assign period  = (elapsed[TIME_W] || (elapsed == '0)) ? '0 : elapsed[TIME_W-1:0];
    assign measured_ns = (period > TIME_W'(guard_ns)) ? (period - TIME_W'(guard_ns)) : '0;

    assign caught = (reads_reg != '0) && (reads_reg < read_limit_reg);

    always_comb
    begin
        mode_wait_next = mode_wait_reg;
        last_pin_next  = last_pin_reg;
        last_time_next = last_time_reg;
        last_ok_next   = last_ok_reg;

        out_next                = '0;
        out_next.next_delay_ns  = TIME_W'(poll_ns);

        if (!mode_wait_reg)
        begin
            if (pin_reg != last_pin_reg)
            begin
                // Arm the wait window on a change to the capture level
                if (pin_reg == capture_level_reg)
                begin
                    out_next.next_delay_ns = TIME_W'(arm_ns);
                    mode_wait_next         = 1'b1;
                    last_time_next         = '0;
                    last_ok_next           = 1'b0;
                end
                last_pin_next = pin_reg;
            end
        end
        else if (caught)
        begin
            if (!last_ok_reg)
            begin
                out_next.next_delay_ns = TIME_W'(first_ns);
            end
            else
            begin
                out_next.next_delay_ns = measured_ns;
            end
            last_time_next          = now_reg;
            last_ok_next            = 1'b1;
            out_next.pulse_valid    = 1'b1;
            out_next.pulse_stamp_ns = stamp_reg;
            out_next.pulse_kind     = capture_level_reg;
        end
        else
        begin
            // Drop back to polling on a missed window
            out_next.pulse_missed = 1'b1;
            mode_wait_next        = 1'b0;
        end

        out_next.wait_mode = mode_wait_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_wait_reg <= 1'b0;
            last_pin_reg  <= 1'b0;
            last_time_reg <= '0;
            last_ok_reg   <= 1'b0;
        end
        else if (fire)
        begin
            mode_wait_reg <= mode_wait_next;
            last_pin_reg  <= last_pin_next;
            last_time_reg <= last_time_next;
            last_ok_reg   <= last_ok_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign next_delay_ns  = out_reg.next_delay_ns;
    assign wait_mode      = out_reg.wait_mode;
    assign pulse_valid    = out_reg.pulse_valid;
    assign pulse_stamp_ns = out_reg.pulse_stamp_ns;
    assign pulse_kind     = out_reg.pulse_kind;
    assign pulse_missed   = out_reg.pulse_missed;

    // A caught pulse keeps the window open, a miss closes it
    a_pulse_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && pulse_valid) |-> (wait_mode && !pulse_missed))
        else $error("pulse reported outside the wait window");

    a_miss_to_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && pulse_missed) |-> !wait_mode)
        else $error("missed window did not return to polling");

    // The state only moves to wait through a poll step
    a_arm_from_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !mode_wait_reg && !caught && mode_wait_next) |=> last_ok_reg == 1'b0)
        else $error("arming did not clear the previous pulse record");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && out_valid_reg && result_stall))
        else $error("input stalled with room in the pipeline");

endmodule
